[hdl/sps_pkg.sv]
// Package with shared types, codes and defaults of the strict priority scheduler.
`timescale 1ns / 1ps
package sps_pkg;

    localparam int QUEUE_DEPTH_DEF = 16;
    localparam int MAX_BURST_DEF   = 8;
    localparam int NUM_QUEUES      = 4;

    // Input function codes
    localparam logic [1:0] FUNC_ENQ   = 2'd0;
    localparam logic [1:0] FUNC_TICK  = 2'd1;
    localparam logic [1:0] FUNC_FLUSH = 2'd2;

    // Result kinds
    localparam logic [1:0] KIND_ENQ     = 2'd0;
    localparam logic [1:0] KIND_SENT    = 2'd1;
    localparam logic [1:0] KIND_NOTHING = 2'd2;
    localparam logic [1:0] KIND_FLUSH   = 2'd3;

    // Enqueue status codes
    localparam logic [1:0] STAT_OK      = 2'd0;
    localparam logic [1:0] STAT_REPLACE = 2'd1;
    localparam logic [1:0] STAT_DROP    = 2'd2;

    // Priority codes at or above this one replace older entries of the stream
    localparam logic [1:0] PRIO_NORMAL = 2'd2;

    // Configuration register indexes
    localparam logic [1:0] CFG_SENDING_ENABLED = 2'd0;
    localparam logic [1:0] CFG_MAX_PER_TICK    = 2'd1;

    localparam logic [3:0] MAX_PER_TICK_RST = 4'd8;

    typedef enum logic [2:0] {
        S_IDLE,
        S_PURGE,
        S_ENQ,
        S_RESP,
        S_TSEL,
        S_TOUT
    } state_t;

    typedef struct packed {
        logic [1:0]  func;
        logic [7:0]  stream_id;
        logic [15:0] packet_tag;
        logic        reliable;
        logic [1:0]  priority_req;
    } in_item_t;

    typedef struct packed {
        logic [1:0]  kind;
        logic [1:0]  status;
        logic [7:0]  sent_stream;
        logic [15:0] sent_tag;
        logic        sent_reliable;
        logic [1:0]  from_queue;
        logic        last;
    } out_item_t;

    typedef struct packed {
        logic [7:0]  stream;
        logic [15:0] tag;
        logic        rel;
    } desc_t;

endpackage

[hdl/strict_priority_packet_scheduler.sv]
// Top level of the strict priority packet scheduler with its queue memory.
`timescale 1ns / 1ps
// Usage
//   in_valid/in_ready/in_data carry one command transaction: enqueue a packet
//   descriptor, send tick, or flush. out_valid/out_ready/out_data return the
//   results; the last result of a command has last set. cfg_valid/cfg_index/
//   cfg_data write sending_enabled (index 0) or max_per_tick (index 1); the
//   port is always ready. Write it only while the block is idle; the block
//   itself does not enforce this. All four queues are circular buffers in
//   one memory of 4*QUEUE_DEPTH descriptors with one write and one read
//   port and registered read data. Commands are taken one at a time. An
//   enqueue to normal or low first compacts the queue through the memory
//   port, one entry per cycle. A tick reads each sent descriptor from
//   memory, then outputs it. Flush empties all queues.
//   Reset clears fill counts, queue pointers and the output valid flag; queue
//   contents need no clearing. A stalled receiver holds the output register
//   and the command in progress waits; nothing is lost.
module strict_priority_packet_scheduler #(
    parameter int QUEUE_DEPTH = sps_pkg::QUEUE_DEPTH_DEF,
    parameter int MAX_BURST   = sps_pkg::MAX_BURST_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  sps_pkg::in_item_t  in_data,
    output logic               out_valid,
    input  logic               out_ready,
    output sps_pkg::out_item_t out_data,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [1:0]         cfg_index,
    input  logic [3:0]         cfg_data
);
    import sps_pkg::*;

    localparam int CW = $clog2(QUEUE_DEPTH + 1);
    localparam int PW = $clog2(QUEUE_DEPTH);
    localparam int AW = $clog2(NUM_QUEUES * QUEUE_DEPTH);
    localparam int KW = $clog2(MAX_BURST + 1);

    // Map queue, head and offset to a memory address, wrapping inside the queue
    function automatic logic [AW-1:0] qaddr(input logic [1:0] q, input logic [PW-1:0] head,
                                            input logic [CW-1:0] off);
        logic [CW:0] sum;
        logic [CW:0] wrapped;
        sum = {{(CW+1-PW){1'b0}}, head} + {1'b0, off};
        wrapped = (sum >= (CW+1)'(QUEUE_DEPTH)) ? sum - (CW+1)'(QUEUE_DEPTH) : sum;
        return AW'(q * QUEUE_DEPTH) + AW'(wrapped);
    endfunction

    state_t            state_reg, state_next;
    in_item_t          item_reg, item_next;
    logic [PW-1:0]     head_reg [NUM_QUEUES];
    logic [PW-1:0]     head_next [NUM_QUEUES];
    logic [CW-1:0]     count_reg [NUM_QUEUES];
    logic [CW-1:0]     count_next [NUM_QUEUES];
    logic [CW-1:0]     idx_reg, idx_next;
    logic [CW-1:0]     wr_reg, wr_next;
    logic              pend_reg, pend_next;
    logic              rem_reg, rem_next;
    logic [KW-1:0]     k_reg, k_next;
    logic              last_reg, last_next;
    logic [1:0]        q_reg, q_next;
    out_item_t         resp_reg, resp_next;
    out_item_t         out_reg, out_next;
    logic              out_valid_reg, out_valid_next;
    logic              en_reg;
    logic [3:0]        max_reg;

    desc_t             mem [NUM_QUEUES * QUEUE_DEPTH];
    desc_t             rd_data_reg;
    logic              mem_we, mem_re;
    logic [AW-1:0]     mem_waddr, mem_raddr;
    desc_t             mem_wdata;

    logic              out_free;
    logic [KW-1:0]     limit;
    logic [1:0]        cq;
    logic              found;
    logic [1:0]        sel_q;
    logic              more_after;

    assign in_ready  = (state_reg == S_IDLE);
    assign cfg_ready = 1'b1;
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;
    assign out_free  = !out_valid_reg || out_ready;
    assign cq        = item_reg.priority_req;

    // Clamp the per-tick limit to 1..MAX_BURST
    always_comb
    begin
        if (max_reg == 4'd0)
            limit = KW'(1);
        else if (int'(max_reg) > MAX_BURST)
            limit = KW'(MAX_BURST);
        else
            limit = KW'(max_reg);
    end

    // Find the highest priority nonempty queue and whether entries remain beyond its head
    always_comb
    begin
        found = 1'b0;
        sel_q = 2'd0;
        for (int j = NUM_QUEUES - 1; j >= 0; j--)
        begin
            if (count_reg[j] != '0)
            begin
                found = 1'b1;
                sel_q = 2'(j);
            end
        end
        more_after = (count_reg[sel_q] > CW'(1));
        for (int j = 0; j < NUM_QUEUES; j++)
        begin
            if (2'(j) != sel_q && count_reg[j] != '0)
                more_after = 1'b1;
        end
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    case (in_data.func)
                        FUNC_ENQ:
                            state_next = (in_data.priority_req >= PRIO_NORMAL &&
                                          count_reg[in_data.priority_req] != '0)
                                         ? S_PURGE : S_ENQ;
                        FUNC_TICK:  state_next = en_reg ? S_TSEL : S_RESP;
                        FUNC_FLUSH: state_next = S_RESP;
                        default:    state_next = S_IDLE;
                    endcase
                end
            end
            S_PURGE:
                if (idx_reg == count_reg[cq] && !pend_reg)
                    state_next = S_ENQ;
            S_ENQ:   state_next = S_RESP;
            S_RESP:  if (out_free) state_next = S_IDLE;
            S_TSEL:  state_next = found ? S_TOUT : S_RESP;
            S_TOUT:  if (out_free) state_next = last_reg ? S_IDLE : S_TSEL;
            default: state_next = S_IDLE;
        endcase
    end

    // Datapath and memory control
    always_comb
    begin
        item_next      = item_reg;
        head_next      = head_reg;
        count_next     = count_reg;
        idx_next       = idx_reg;
        wr_next        = wr_reg;
        pend_next      = 1'b0;
        rem_next       = rem_reg;
        k_next         = k_reg;
        last_next      = last_reg;
        q_next         = q_reg;
        resp_next      = resp_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg && !out_ready;
        mem_we         = 1'b0;
        mem_re         = 1'b0;
        mem_waddr      = '0;
        mem_raddr      = '0;
        mem_wdata      = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    item_next = in_data;
                    idx_next  = '0;
                    wr_next   = '0;
                    rem_next  = 1'b0;
                    k_next    = '0;
                    resp_next = '0;
                    resp_next.last = 1'b1;
                    if (in_data.func == FUNC_TICK)
                        resp_next.kind = KIND_NOTHING;
                    if (in_data.func == FUNC_FLUSH)
                    begin
                        resp_next.kind = KIND_FLUSH;
                        for (int j = 0; j < NUM_QUEUES; j++)
                            count_next[j] = '0;
                    end
                end
            end
            S_PURGE:
            begin
                // Read the next entry, write back the kept one from last cycle
                if (idx_reg != count_reg[cq])
                begin
                    mem_re    = 1'b1;
                    mem_raddr = qaddr(cq, head_reg[cq], idx_reg);
                    idx_next  = idx_reg + CW'(1);
                    pend_next = 1'b1;
                end
                if (pend_reg)
                begin
                    if (rd_data_reg.stream != item_reg.stream_id)
                    begin
                        mem_we    = 1'b1;
                        mem_waddr = qaddr(cq, head_reg[cq], wr_reg);
                        mem_wdata = rd_data_reg;
                        wr_next   = wr_reg + CW'(1);
                    end
                    else
                        rem_next = 1'b1;
                end
                else if (idx_reg == count_reg[cq])
                    count_next[cq] = wr_reg;
            end
            S_ENQ:
            begin
                resp_next.kind = KIND_ENQ;
                resp_next.last = 1'b1;
                if (count_reg[cq] >= CW'(QUEUE_DEPTH))
                    resp_next.status = STAT_DROP;
                else
                begin
                    mem_we     = 1'b1;
                    mem_waddr  = qaddr(cq, head_reg[cq], count_reg[cq]);
                    mem_wdata  = '{stream: item_reg.stream_id, tag: item_reg.packet_tag,
                                   rel: item_reg.reliable};
                    count_next[cq]   = count_reg[cq] + CW'(1);
                    resp_next.status = rem_reg ? STAT_REPLACE : STAT_OK;
                end
            end
            S_RESP:
            begin
                if (out_free)
                begin
                    out_next       = resp_reg;
                    out_valid_next = 1'b1;
                end
            end
            S_TSEL:
            begin
                // Pop the head of the highest nonempty queue
                if (found)
                begin
                    mem_re    = 1'b1;
                    mem_raddr = qaddr(sel_q, head_reg[sel_q], '0);
                    head_next[sel_q] = (head_reg[sel_q] == PW'(QUEUE_DEPTH - 1))
                                       ? '0 : head_reg[sel_q] + PW'(1);
                    count_next[sel_q] = count_reg[sel_q] - CW'(1);
                    q_next    = sel_q;
                    k_next    = k_reg + KW'(1);
                    last_next = ((k_reg + KW'(1)) >= limit) || !more_after;
                end
            end
            S_TOUT:
            begin
                if (out_free)
                begin
                    out_next.kind          = KIND_SENT;
                    out_next.status        = STAT_OK;
                    out_next.sent_stream   = rd_data_reg.stream;
                    out_next.sent_tag      = rd_data_reg.tag;
                    out_next.sent_reliable = rd_data_reg.rel;
                    out_next.from_queue    = q_reg;
                    out_next.last          = last_reg;
                    out_valid_next         = 1'b1;
                end
            end
            default:
            begin
                out_valid_next = out_valid_reg && !out_ready;
            end
        endcase
    end

    // Queue memory
    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[mem_waddr] <= mem_wdata;
        if (mem_re)
            rd_data_reg <= mem[mem_raddr];
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        item_reg <= item_next;
        idx_reg  <= idx_next;
        wr_reg   <= wr_next;
        rem_reg  <= rem_next;
        k_reg    <= k_next;
        last_reg <= last_next;
        q_reg    <= q_next;
        resp_reg <= resp_next;
        out_reg  <= out_next;
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
            en_reg        <= 1'b0;
            max_reg       <= MAX_PER_TICK_RST;
            for (int j = 0; j < NUM_QUEUES; j++)
            begin
                head_reg[j]  <= '0;
                count_reg[j] <= '0;
            end
        end
        else
        begin
            state_reg     <= state_next;
            pend_reg      <= pend_next;
            out_valid_reg <= out_valid_next;
            head_reg      <= head_next;
            count_reg     <= count_next;
            if (cfg_valid && cfg_index == CFG_SENDING_ENABLED)
                en_reg <= cfg_data[0];
            if (cfg_valid && cfg_index == CFG_MAX_PER_TICK)
                max_reg <= cfg_data;
        end
    end

endmodule
